/* design/tsma_pkg.sv */
// tsma_pkg: shared types, codes and constants of the send memory accounting unit
// no dependencies
`default_nettype none
package tsma_pkg;

  localparam int unsigned FlowCountDefault = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  // function codes
  localparam logic [2:0] FuncOpen    = 3'd0;
  localparam logic [2:0] FuncRatio   = 3'd1;
  localparam logic [2:0] FuncWrite   = 3'd2;
  localparam logic [2:0] FuncCommit  = 3'd3;
  localparam logic [2:0] FuncAck     = 3'd4;
  localparam logic [2:0] FuncRelease = 3'd5;

  // status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StSndbuf = 2'd1;
  localparam logic [1:0] StHigh   = 2'd2;
  localparam logic [1:0] StErr    = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegInitCap  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxCap   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLowMark  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPresMark = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHighMark = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDefNum   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDefDen   = 3'd6;

  localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] Uint32Max = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  flow_id;
    logic [15:0] byte_count;
    logic [31:0] cong_window;
    logic [31:0] send_avail;
    logic [31:0] ratio_num;
    logic [31:0] ratio_den;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        grew;
    logic [31:0] send_avail_out;
    logic [31:0] flow_capacity;
    logic [31:0] flow_queued;
    logic [47:0] total_charged;
    logic        under_pressure;
    logic        underflow;
  } rsp_t;

  // front-to-back work item
  typedef struct packed {
    req_t req;
    logic in_range;
  } work_t;

endpackage
`default_nettype wire

/* design/tsma_if.sv */
// tsma_req_if / tsma_rsp_if: valid/ready channels for items and results
// depends on tsma_pkg
`default_nettype none
interface tsma_req_if;
  logic valid;
  logic ready;
  tsma_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsma_rsp_if;
  logic valid;
  logic ready;
  tsma_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/tsma_front.sv */
// tsma_front: accepts items, checks flow range and queues them for the back end
// depends on tsma_pkg
`default_nettype none
module tsma_front #(
  parameter int unsigned FlowCount = tsma_pkg::FlowCountDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tsma_pkg::req_t in_data_i,
  output logic               wk_valid_o,
  input  wire logic          wk_ready_i,
  output tsma_pkg::work_t    wk_data_o
);
  // two-entry queue
  tsma_pkg::work_t buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic rd_q, rd_d, wr_q, wr_d;
  logic push, pop;
  tsma_pkg::work_t w;

  // classify
  always_comb begin
    w.req = in_data_i;
    w.in_range = ({28'd0, in_data_i.flow_id} < 32'(FlowCount));
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign wk_valid_o = (cnt_q != 2'd0);
  assign pop = wk_valid_o && wk_ready_i;
  assign wk_data_o = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    rd_d = pop ? ~rd_q : rd_q;
    wr_d = push ? ~wr_q : wr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= w;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count missed a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop)
    else $error("pop from empty queue");
endmodule
`default_nettype wire

/* design/tsma_div.sv */
// tsma_div: radix-2 restoring divider, 64-bit dividend by 32-bit divisor
// depends on nothing
`default_nettype none
module tsma_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [63:0] quot_o
);
  logic [63:0] quo_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [6:0] cnt_q;
  logic busy_q;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_q[31:0], quo_q[63]};
  assign trial = shifted - {1'b0, den_q};
  assign quot_o = quo_q;
  assign done_o = busy_q && (cnt_q == 7'd0);

  // one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 7'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 7'd64;
    end else if (busy_q && cnt_q != 7'd0) begin
      cnt_q <= cnt_q - 7'd1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= 33'd0;
      den_q <= divisor_i;
    end else if (busy_q && cnt_q != 7'd0) begin
      if (!trial[32]) begin
        rem_q <= trial;
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

/* design/tsma_back.sv */
// tsma_back: executes one item at a time against the flow table and global total
// depends on tsma_pkg, tsma_div
`default_nettype none
module tsma_back #(
  parameter int unsigned FlowCount = tsma_pkg::FlowCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wk_valid_i,
  output logic             wk_ready_o,
  input  wire tsma_pkg::work_t wk_data_i,
  input  wire logic        cfg_we_i,
  input  wire logic [tsma_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tsma_pkg::CfgDataW-1:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output tsma_pkg::rsp_t   out_data_o
);
  localparam int unsigned IdxW = (FlowCount > 1) ? $clog2(FlowCount) : 1;

  typedef enum logic [2:0] {
    SIdle, SRead, SMul, SDiv, SGrow, SExec, SOut
  } state_e;

  state_e state_q;
  tsma_pkg::req_t r_q;
  logic inr_q;

  // configuration
  logic [31:0] init_cap_q, max_cap_q, def_num_q, def_den_q;
  logic [47:0] low_q, pres_q, high_q;

  // flow table
  logic [FlowCount-1:0] act_q;
  logic [31:0] cap_q [FlowCount];
  logic [31:0] que_q [FlowCount];
  logic [31:0] num_q [FlowCount];
  logic [31:0] den_q [FlowCount];
  logic [47:0] tot_q;
  logic pf_q;

  // registered entry view
  logic e_act_q;
  logic [31:0] e_cap_q, e_que_q, e_num_q, e_den_q;
  logic [63:0] prod_q;
  logic [31:0] target_q;
  logic [32:0] sum_q;
  logic grow_q;
  logic [IdxW-1:0] idx;
  tsma_pkg::rsp_t o_q;

  logic div_start, div_done;
  logic [63:0] div_q;

  tsma_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(prod_q), .divisor_i(e_den_q),
    .done_o(div_done), .quot_o(div_q)
  );

  assign idx = r_q.flow_id[IdxW-1:0];
  assign wk_ready_o = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o = o_q;
  assign div_start = (state_q == SMul);

  // hysteresis
  function automatic logic next_pf(input logic pf, input logic [47:0] t,
                                   input logic [47:0] pm, input logic [47:0] lm);
    logic n;
    begin
      n = pf;
      if (!pf && t >= pm) n = 1'b1;
      else if (pf && t <= lm) n = 1'b0;
      return n;
    end
  endfunction

  // clamped growth target
  logic [63:0] tgt_c;
  always_comb begin
    tgt_c = div_q;
    if (tgt_c < {32'd0, init_cap_q}) tgt_c = {32'd0, init_cap_q};
    if (tgt_c > {32'd0, max_cap_q}) tgt_c = {32'd0, max_cap_q};
  end

  // execute step combinational values
  logic [32:0] qsum;
  logic [48:0] tsum;
  logic [31:0] amt32;
  logic [47:0] amt48;
  logic uf;
  logic [31:0] avail_o;
  logic [47:0] room;
  always_comb begin
    qsum = {1'b0, e_que_q} + {17'd0, r_q.byte_count};
    tsum = {1'b0, tot_q} + {33'd0, r_q.byte_count};
    uf = 1'b0;
    if (r_q.func == tsma_pkg::FuncAck) begin
      amt32 = {16'd0, r_q.byte_count};
      if (amt32 > e_que_q) begin
        amt32 = e_que_q;
        uf = 1'b1;
      end
    end else begin
      amt32 = e_que_q;
    end
    amt48 = {16'd0, amt32};
    if (amt48 > tot_q) begin
      amt48 = tot_q;
      uf = 1'b1;
    end
    avail_o = grow_q ? sum_q[31:0] : r_q.send_avail;
    room = high_q - tot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      act_q <= '0;
      tot_q <= '0;
      pf_q <= 1'b0;
      init_cap_q <= 32'd8192;
      max_cap_q <= 32'd65535;
      low_q <= 48'd0;
      pres_q <= 48'd0;
      high_q <= 48'd1;
      def_num_q <= 32'd2;
      def_den_q <= 32'd1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tsma_pkg::RegInitCap:  init_cap_q <= cfg_data_i[31:0];
          tsma_pkg::RegMaxCap:   max_cap_q <= cfg_data_i[31:0];
          tsma_pkg::RegLowMark:  low_q <= cfg_data_i;
          tsma_pkg::RegPresMark: pres_q <= cfg_data_i;
          tsma_pkg::RegHighMark: high_q <= cfg_data_i;
          tsma_pkg::RegDefNum:   def_num_q <= cfg_data_i[31:0];
          tsma_pkg::RegDefDen:   def_den_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      case (state_q)
        SIdle: begin
          if (wk_valid_i) begin
            r_q <= wk_data_i.req;
            inr_q <= wk_data_i.in_range;
            state_q <= SRead;
          end
        end
        SRead: begin
          // an inactive entry reads its capacity and queued count as zero
          e_act_q <= act_q[idx];
          e_cap_q <= act_q[idx] ? cap_q[idx] : 32'd0;
          e_que_q <= act_q[idx] ? que_q[idx] : 32'd0;
          e_num_q <= num_q[idx];
          e_den_q <= den_q[idx];
          grow_q <= 1'b0;
          if (inr_q && act_q[idx] && r_q.func == tsma_pkg::FuncWrite &&
              num_q[idx] != 32'd0 && den_q[idx] != 32'd0)
            state_q <= SMul;
          else
            state_q <= SExec;
        end
        SMul: state_q <= SDiv;
        SDiv: begin
          if (div_done) begin
            target_q <= tgt_c[31:0];
            state_q <= SGrow;
          end
        end
        SGrow: begin
          grow_q <= (target_q[31:0] > e_cap_q) && !pf_q;
          sum_q <= {1'b0, r_q.send_avail} + {1'b0, target_q[31:0] - e_cap_q};
          state_q <= SExec;
        end
        SExec: begin
          o_q.status <= tsma_pkg::StOk;
          o_q.grew <= 1'b0;
          o_q.send_avail_out <= r_q.send_avail;
          o_q.flow_capacity <= inr_q ? e_cap_q : 32'd0;
          o_q.flow_queued <= inr_q ? e_que_q : 32'd0;
          o_q.total_charged <= tot_q;
          o_q.under_pressure <= pf_q;
          o_q.underflow <= 1'b0;
          if (!inr_q || r_q.func > tsma_pkg::FuncRelease) begin
            o_q.status <= tsma_pkg::StErr;
          end else if (r_q.func == tsma_pkg::FuncOpen) begin
            if (e_act_q) begin
              o_q.status <= tsma_pkg::StErr;
            end else begin
              act_q[idx] <= 1'b1;
              cap_q[idx] <= init_cap_q;
              que_q[idx] <= 32'd0;
              num_q[idx] <= def_num_q;
              den_q[idx] <= def_den_q;
              o_q.send_avail_out <= init_cap_q;
              o_q.flow_capacity <= init_cap_q;
              o_q.flow_queued <= 32'd0;
            end
          end else if (!e_act_q) begin
            o_q.status <= tsma_pkg::StErr;
          end else begin
            case (r_q.func)
              tsma_pkg::FuncRatio: begin
                if (r_q.ratio_num == 32'd0 || r_q.ratio_den == 32'd0) begin
                  o_q.status <= tsma_pkg::StErr;
                end else begin
                  num_q[idx] <= r_q.ratio_num;
                  den_q[idx] <= r_q.ratio_den;
                end
              end
              tsma_pkg::FuncWrite: begin
                if (e_num_q == 32'd0 || e_den_q == 32'd0) begin
                  o_q.status <= tsma_pkg::StErr;
                end else if (grow_q && sum_q[32]) begin
                  o_q.status <= tsma_pkg::StErr;
                end else begin
                  if (grow_q) begin
                    cap_q[idx] <= target_q[31:0];
                    o_q.flow_capacity <= target_q[31:0];
                    o_q.grew <= 1'b1;
                    o_q.send_avail_out <= avail_o;
                  end
                  if (r_q.byte_count != 16'd0) begin
                    if ({16'd0, r_q.byte_count} > avail_o)
                      o_q.status <= tsma_pkg::StSndbuf;
                    else if (tot_q > high_q || {32'd0, r_q.byte_count} > room)
                      o_q.status <= tsma_pkg::StHigh;
                  end
                end
              end
              tsma_pkg::FuncCommit: begin
                if (r_q.byte_count != 16'd0) begin
                  que_q[idx] <= qsum[32] ? tsma_pkg::Uint32Max : qsum[31:0];
                  o_q.flow_queued <= qsum[32] ? tsma_pkg::Uint32Max : qsum[31:0];
                  tot_q <= tsum[48] ? tsma_pkg::Mask48 : tsum[47:0];
                  o_q.total_charged <= tsum[48] ? tsma_pkg::Mask48 : tsum[47:0];
                  pf_q <= next_pf(pf_q, tsum[48] ? tsma_pkg::Mask48 : tsum[47:0],
                                  pres_q, low_q);
                  o_q.under_pressure <= next_pf(pf_q,
                    tsum[48] ? tsma_pkg::Mask48 : tsum[47:0], pres_q, low_q);
                end
              end
              tsma_pkg::FuncAck: begin
                if (r_q.byte_count != 16'd0) begin
                  que_q[idx] <= e_que_q - amt48[31:0];
                  o_q.flow_queued <= e_que_q - amt48[31:0];
                  tot_q <= tot_q - amt48;
                  o_q.total_charged <= tot_q - amt48;
                  pf_q <= next_pf(pf_q, tot_q - amt48, pres_q, low_q);
                  o_q.under_pressure <= next_pf(pf_q, tot_q - amt48, pres_q, low_q);
                  o_q.underflow <= uf;
                end
              end
              default: begin
                tot_q <= tot_q - amt48;
                o_q.total_charged <= tot_q - amt48;
                pf_q <= next_pf(pf_q, tot_q - amt48, pres_q, low_q);
                o_q.under_pressure <= next_pf(pf_q, tot_q - amt48, pres_q, low_q);
                o_q.underflow <= uf;
                act_q[idx] <= 1'b0;
                cap_q[idx] <= 32'd0;
                que_q[idx] <= 32'd0;
                num_q[idx] <= 32'd0;
                den_q[idx] <= 32'd0;
                o_q.flow_capacity <= 32'd0;
                o_q.flow_queued <= 32'd0;
              end
            endcase
          end
          state_q <= SOut;
        end
        SOut: begin
          if (out_ready_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // product registered before the divide
  always_ff @(posedge clk_i) begin
    if (state_q == SRead) prod_q <= r_q.cong_window * num_q[idx];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut && !out_ready_i) |=> (state_q == SOut && $stable(o_q)))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SExec) |=> (state_q == SOut))
    else $error("execute did not produce a result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SMul) |=> (state_q == SDiv))
    else $error("divide not started");
endmodule
`default_nettype wire

/* design/tcp_send_memory_accounting_unit.sv */
// tcp_send_memory_accounting_unit: top level, front queue plus execution back end
// depends on tsma_pkg, tsma_if, tsma_front, tsma_back
//
// channel  dir  handshake      payload
// in_if    in   valid/ready    tsma_pkg::req_t
// out_if   out  valid/ready    tsma_pkg::rsp_t
// cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// most items pass SIdle, SRead, SExec and SOut in the back end, SOut held for the result handshake
// a write request on an active flow with a nonzero ratio also passes SMul, SDiv and
// SGrow, using the one-bit-per-cycle divider for the growth target
// the front queue holds two items, so input is taken while a result waits
// reset clears flow table valid bits, totals and control at once
`default_nettype none
module tcp_send_memory_accounting_unit #(
  parameter int unsigned FlowCount = tsma_pkg::FlowCountDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tsma_req_if.sink  in_if,
  tsma_rsp_if.source out_if,
  input  wire logic cfg_we_i,
  input  wire logic [tsma_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tsma_pkg::CfgDataW-1:0] cfg_data_i
);
  logic wk_valid, wk_ready;
  tsma_pkg::work_t wk_data;

  tsma_front #(.FlowCount(FlowCount)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .wk_valid_o(wk_valid), .wk_ready_i(wk_ready), .wk_data_o(wk_data)
  );

  tsma_back #(.FlowCount(FlowCount)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .wk_valid_i(wk_valid), .wk_ready_o(wk_ready), .wk_data_i(wk_data),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );
endmodule
`default_nettype wire
